@@ hdl/rv2x_pkg.sv @@
// Shared types, opcodes and byte-segment builders for the RISC-V to x86-64 emitter.
`timescale 1ns / 1ps
package rv2x_pkg;

  localparam int unsigned SegBytes = 10;
  localparam int unsigned NumSegs  = 8;

  localparam logic [6:0] OpLui    = 7'h37;
  localparam logic [6:0] OpAuipc  = 7'h17;
  localparam logic [6:0] OpImm    = 7'h13;
  localparam logic [6:0] OpReg    = 7'h33;
  localparam logic [6:0] OpLoad   = 7'h03;
  localparam logic [6:0] OpStore  = 7'h23;
  localparam logic [6:0] OpFload  = 7'h07;
  localparam logic [6:0] OpFstore = 7'h27;
  localparam logic [6:0] OpFp     = 7'h53;
  localparam logic [6:0] OpFmadd  = 7'h43;
  localparam logic [6:0] OpFmsub  = 7'h47;
  localparam logic [6:0] OpFnmsub = 7'h4B;
  localparam logic [6:0] OpFnmadd = 7'h4F;
  localparam logic [6:0] OpBranch = 7'h63;
  localparam logic [6:0] OpJal    = 7'h6F;
  localparam logic [6:0] OpJalr   = 7'h67;

  localparam logic [1:0] OutNone = 2'd0;
  localparam logic [1:0] OutOk   = 2'd1;
  localparam logic [1:0] OutEnd  = 2'd2;

  localparam logic [1:0] CfgMemHelper = 2'd0;
  localparam logic [1:0] CfgFpHelper  = 2'd1;
  localparam logic [1:0] CfgFpEnable  = 2'd2;
  localparam logic [1:0] CfgPcOffset  = 2'd3;

  // host registers
  localparam logic [2:0] RegEax = 3'd0;
  localparam logic [2:0] RegEcx = 3'd1;
  localparam logic [2:0] RegEdx = 3'd2;
  localparam logic [2:0] RegEsi = 3'd6;

  typedef struct packed {
    logic [2:0]  insn_length;
    logic [31:0] insn_pc;
    logic [31:0] instruction;
  } item_t;

  typedef struct packed {
    logic [31:0] pc_field_offset;
    logic        fp_enable;
    logic [63:0] fp_helper_address;
    logic [63:0] mem_helper_address;
  } cfg_t;

  // one run of bytes; byte 0 goes out first, xs marks an exit slot at byte 2
  typedef struct packed {
    logic [SegBytes-1:0][7:0] b;
    logic [3:0]               len;
    logic                     xs;
  } seg_t;

  typedef struct packed {
    seg_t [NumSegs-1:0] seg;
    logic [2:0]         last_seg;
    logic [1:0]         outcome;
  } prog_t;

  function automatic seg_t seg_raw(input logic [3:0] n, input logic [7:0] b0,
                                   input logic [7:0] b1, input logic [7:0] b2,
                                   input logic [7:0] b3, input logic [7:0] b4,
                                   input logic [7:0] b5);
    seg_t s;
    s      = '0;
    s.len  = n;
    s.b[0] = b0;
    s.b[1] = b1;
    s.b[2] = b2;
    s.b[3] = b3;
    s.b[4] = b4;
    s.b[5] = b5;
    return s;
  endfunction

  function automatic seg_t seg_mov(input logic [2:0] reg_i, input logic [31:0] imm);
    return seg_raw(4'd5, {5'b10111, reg_i}, imm[7:0], imm[15:8], imm[23:16],
                   imm[31:24], 8'h00);
  endfunction

  function automatic seg_t seg_hm(input logic [7:0] opc, input logic [2:0] reg_i,
                                  input logic [31:0] disp);
    return seg_raw(4'd6, opc, {2'b10, reg_i, 3'b011}, disp[7:0], disp[15:8],
                   disp[23:16], disp[31:24]);
  endfunction

  function automatic seg_t seg_rd(input logic [2:0] reg_i, input logic [4:0] r);
    return (r == 5'd0) ? seg_mov(reg_i, 32'h0) : seg_hm(8'h8B, reg_i, {25'd0, r, 2'b00});
  endfunction

  // empty when the target is x0
  function automatic seg_t seg_wr(input logic [4:0] r, input logic [2:0] reg_i);
    return (r == 5'd0) ? seg_t'('0) : seg_hm(8'h89, reg_i, {25'd0, r, 2'b00});
  endfunction

  function automatic seg_t seg_alu(input logic [7:0] op);
    return seg_raw(4'd2, op, 8'hC8, 8'h00, 8'h00, 8'h00, 8'h00);
  endfunction

  function automatic seg_t seg_setcc(input logic [7:0] cc);
    return seg_raw(4'd6, 8'h0F, cc, 8'hC0, 8'h0F, 8'hB6, 8'hC0);
  endfunction

  function automatic seg_t seg_imm64(input logic [63:0] a);
    seg_t s;
    s      = '0;
    s.len  = 4'd10;
    s.b[0] = 8'h48;
    s.b[1] = 8'hB8;
    for (int i = 0; i < 8; i++) s.b[i+2] = a[8*i +: 8];
    return s;
  endfunction

endpackage

@@ hdl/riscv_to_x86_code_emitter_top.sv @@
// Top level: configuration registers, input register, decoder and byte emitter.
//
//  channel   | dir | handshake            | payload
//  s_axis    | in  | tvalid/tready        | tdata: instruction, insn_pc, insn_length
//  m_axis    | out | tvalid/tready        | tdata: code_byte; tuser; tlast = last
//  cfg       | in  | cfg_we_i (no wait)   | cfg_idx_i, cfg_data_i
//
// Each instruction produces 1 to 41 output items, one per cycle while m_axis accepts them; a branch is the
// longest at 41. Throughput is limited by the emitter's one-byte-per-cycle walk.
// The next instruction is decoded from the input register while the current one
// drains, so items follow with no gap. m_axis stalls hold the output register and
// back-pressure through the emitter to s_axis. Reset clears all valid state and
// restores the configuration defaults.
`timescale 1ns / 1ps
module riscv_to_x86_code_emitter_top import rv2x_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // instruction[31:0], insn_pc[63:32], insn_length[66:64]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // code_byte
  output logic [3:0]  m_axis_tuser_o,  // byte_valid[0], exit_slot[1], outcome[3:2]
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  cfg_t  cfg_q;
  item_t in_q;
  logic  in_valid_q;
  logic  take;
  prog_t prog;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{pc_field_offset: 32'd128, fp_enable: 1'b0,
                 fp_helper_address: 64'd0, mem_helper_address: 64'd0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMemHelper: cfg_q.mem_helper_address <= cfg_data_i;
        CfgFpHelper:  cfg_q.fp_helper_address  <= cfg_data_i;
        CfgFpEnable:  cfg_q.fp_enable          <= cfg_data_i[0];
        CfgPcOffset:  cfg_q.pc_field_offset    <= cfg_data_i[31:0];
        default:      cfg_q.fp_enable          <= cfg_q.fp_enable;
      endcase
    end
  end

  assign s_axis_tready_o = !in_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) in_q <= item_t'(s_axis_tdata_i[66:0]);
  end

  rv2x_decode u_decode (
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .prog_o (prog)
  );

  rv2x_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .prog_valid_i    (in_valid_q),
    .prog_i          (prog),
    .take_o          (take),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

@@ hdl/rv2x_decode.sv @@
// Decodes one RISC-V instruction into a list of x86-64 byte segments.
`timescale 1ns / 1ps
module rv2x_decode import rv2x_pkg::*; (
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output prog_t prog_o
);

  logic [31:0] insn, pc, nxt, imm_i, imm_b, imm_j;
  logic [6:0]  op, f7;
  logic [4:0]  rd, rs1, rs2;
  logic [2:0]  f3;
  logic [1:0]  outc;
  logic [7:0]  cc;
  logic        is_fp;
  seg_t        a [NumSegs];
  seg_t        hs [NumSegs];
  logic [63:0] haddr;

  assign insn  = item_i.instruction;
  assign pc    = item_i.insn_pc;
  assign nxt   = pc + {29'd0, item_i.insn_length};
  assign op    = insn[6:0];
  assign rd    = insn[11:7];
  assign f3    = insn[14:12];
  assign rs1   = insn[19:15];
  assign rs2   = insn[24:20];
  assign f7    = insn[31:25];
  assign imm_i = {{20{insn[31]}}, insn[31:20]};
  assign imm_b = {{19{insn[31]}}, insn[31], insn[7], insn[30:25], insn[11:8], 1'b0};
  assign imm_j = {{11{insn[31]}}, insn[31], insn[19:12], insn[20], insn[30:21], 1'b0};
  assign is_fp = (op == OpFload) || (op == OpFstore) || (op == OpFp) || (op == OpFmadd) ||
                 (op == OpFmsub) || (op == OpFnmsub) || (op == OpFnmadd);
  assign haddr = is_fp ? cfg_i.fp_helper_address : cfg_i.mem_helper_address;

  always_comb begin
    unique case (f3)
      3'd0:    cc = 8'h84;
      3'd1:    cc = 8'h85;
      3'd4:    cc = 8'h8C;
      3'd5:    cc = 8'h8D;
      3'd6:    cc = 8'h82;
      default: cc = 8'h83;
    endcase
  end

  // helper call: rdi=hart, esi=insn, edx=pc, call helper, test, jne exit
  always_comb begin
    hs[0]    = seg_raw(4'd3, 8'h48, 8'h89, 8'hDF, 8'h00, 8'h00, 8'h00);
    hs[1]    = seg_mov(RegEsi, insn);
    hs[2]    = seg_mov(RegEdx, pc);
    hs[3]    = seg_imm64(haddr);
    hs[4]    = seg_raw(4'd2, 8'hFF, 8'hD0, 8'h00, 8'h00, 8'h00, 8'h00);
    hs[5]    = seg_raw(4'd2, 8'h85, 8'hC0, 8'h00, 8'h00, 8'h00, 8'h00);
    hs[6]    = seg_raw(4'd6, 8'h0F, 8'h85, 8'h00, 8'h00, 8'h00, 8'h00);
    hs[6].xs = 1'b1;
    hs[7]    = '0;
  end

  always_comb begin
    for (int i = 0; i < NumSegs; i++) a[i] = '0;
    outc = OutNone;
    unique case (op)
      OpLui: begin
        a[0] = seg_mov(RegEax, {insn[31:12], 12'h000});
        a[1] = seg_wr(rd, RegEax);
        outc = OutOk;
      end
      OpAuipc: begin
        a[0] = seg_mov(RegEax, pc + {insn[31:12], 12'h000});
        a[1] = seg_wr(rd, RegEax);
        outc = OutOk;
      end
      OpImm: begin
        if (!((f3 == 3'd1 && f7 != 7'h00) ||
              (f3 == 3'd5 && f7 != 7'h00 && f7 != 7'h20))) begin
          outc = OutOk;
          a[0] = seg_rd(RegEax, rs1);
          a[1] = seg_mov(RegEcx, imm_i);
          a[3] = seg_wr(rd, RegEax);
          unique case (f3)
            3'd0: a[2] = seg_alu(8'h01);
            3'd4: a[2] = seg_alu(8'h31);
            3'd6: a[2] = seg_alu(8'h09);
            3'd7: a[2] = seg_alu(8'h21);
            3'd2: begin
              a[2] = seg_alu(8'h39);
              a[3] = seg_setcc(8'h9C);
              a[4] = seg_wr(rd, RegEax);
            end
            3'd3: begin
              a[2] = seg_alu(8'h39);
              a[3] = seg_setcc(8'h92);
              a[4] = seg_wr(rd, RegEax);
            end
            3'd1: begin
              a[1] = seg_raw(4'd3, 8'hC1, 8'hE0, {3'd0, rs2}, 8'h00, 8'h00, 8'h00);
              a[2] = seg_wr(rd, RegEax);
              a[3] = '0;
            end
            default: begin
              a[1] = seg_raw(4'd3, 8'hC1, (f7 == 7'h20) ? 8'hF8 : 8'hE8, {3'd0, rs2},
                             8'h00, 8'h00, 8'h00);
              a[2] = seg_wr(rd, RegEax);
              a[3] = '0;
            end
          endcase
        end
      end
      OpReg: begin
        if ((f7 == 7'h00 || f7 == 7'h20) &&
            !(f7 != 7'h00 && f3 != 3'd0 && f3 != 3'd5)) begin
          outc = OutOk;
          a[0] = seg_rd(RegEax, rs1);
          a[1] = seg_rd(RegEcx, rs2);
          a[3] = seg_wr(rd, RegEax);
          unique case (f3)
            3'd0: a[2] = seg_alu((f7 == 7'h20) ? 8'h29 : 8'h01);
            3'd4: a[2] = seg_alu(8'h31);
            3'd6: a[2] = seg_alu(8'h09);
            3'd7: a[2] = seg_alu(8'h21);
            3'd2: begin
              a[2] = seg_alu(8'h39);
              a[3] = seg_setcc(8'h9C);
              a[4] = seg_wr(rd, RegEax);
            end
            3'd3: begin
              a[2] = seg_alu(8'h39);
              a[3] = seg_setcc(8'h92);
              a[4] = seg_wr(rd, RegEax);
            end
            3'd1: a[2] = seg_raw(4'd2, 8'hD3, 8'hE0, 8'h00, 8'h00, 8'h00, 8'h00);
            default: a[2] = seg_raw(4'd2, 8'hD3, (f7 == 7'h20) ? 8'hF8 : 8'hE8,
                                    8'h00, 8'h00, 8'h00, 8'h00);
          endcase
        end
      end
      OpLoad, OpStore: begin
        if (!((op == OpLoad && f3 == 3'd3) || (op == OpStore && f3 > 3'd2))) begin
          outc = OutOk;
          for (int i = 0; i < NumSegs; i++) a[i] = hs[i];
        end
      end
      OpFload, OpFstore, OpFp, OpFmadd, OpFmsub, OpFnmsub, OpFnmadd: begin
        if (cfg_i.fp_enable) begin
          outc = OutOk;
          for (int i = 0; i < NumSegs; i++) a[i] = hs[i];
        end
      end
      OpBranch: begin
        if (f3 != 3'd2 && f3 != 3'd3) begin
          outc = OutEnd;
          a[0] = seg_rd(RegEax, rs1);
          a[1] = seg_rd(RegEcx, rs2);
          a[2] = seg_alu(8'h39);
          a[3] = seg_raw(4'd6, 8'h0F, cc, 8'h0A, 8'h00, 8'h00, 8'h00);
          a[4] = seg_mov(RegEax, nxt);
          a[5] = seg_raw(4'd5, 8'hE9, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00);
          a[6] = seg_mov(RegEax, pc + imm_b);
          a[7] = seg_hm(8'h89, RegEax, cfg_i.pc_field_offset);
        end
      end
      OpJal: begin
        outc = OutEnd;
        a[0] = seg_mov(RegEax, nxt);
        a[1] = seg_wr(rd, RegEax);
        a[2] = seg_mov(RegEax, pc + imm_j);
        a[3] = seg_hm(8'h89, RegEax, cfg_i.pc_field_offset);
      end
      OpJalr: begin
        if (f3 == 3'd0) begin
          outc = OutEnd;
          a[0] = seg_rd(RegEax, rs1);
          a[1] = seg_mov(RegEcx, imm_i);
          a[2] = seg_alu(8'h01);
          a[3] = seg_raw(4'd3, 8'h83, 8'hE0, 8'hFE, 8'h00, 8'h00, 8'h00);
          a[4] = seg_mov(RegEcx, nxt);
          a[5] = seg_wr(rd, RegEcx);
          a[6] = seg_hm(8'h89, RegEax, cfg_i.pc_field_offset);
        end
      end
      default: outc = OutNone;
    endcase
  end

  // pack non-empty segments to the front
  always_comb begin
    logic [3:0] k;
    k = '0;
    prog_o = '0;
    prog_o.outcome = outc;
    for (int i = 0; i < NumSegs; i++) begin
      if (a[i].len != 4'd0) begin
        prog_o.seg[k[2:0]] = a[i];
        prog_o.last_seg    = k[2:0];
        k                  = k + 4'd1;
      end
    end
    if (outc == OutNone) prog_o.seg = '0;
  end

endmodule

@@ hdl/rv2x_emit.sv @@
// Walks the decoded segments, sending one code byte per item into an output register.
`timescale 1ns / 1ps
module rv2x_emit import rv2x_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       prog_valid_i,
  input  prog_t      prog_i,
  output logic       take_o,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // code_byte
  output logic [3:0] m_axis_tuser_o,   // byte_valid, exit_slot, outcome[1:0]
  output logic       m_axis_tlast_o
);

  prog_t      prog_q;
  logic       busy_q;
  logic [2:0] si_q, si_d;
  logic [3:0] bi_q, bi_d;
  logic       out_valid_q;
  logic [7:0] byte_q;
  logic [3:0] user_q;
  logic       last_q;

  seg_t       cur;
  logic       out_ready, emit, seg_end, item_end, none;

  assign cur       = prog_q.seg[si_q];
  assign none      = (prog_q.outcome == OutNone);
  assign out_ready = !out_valid_q || m_axis_tready_i;
  assign emit      = busy_q && out_ready;
  assign seg_end   = (bi_q == cur.len - 4'd1);
  assign item_end  = none || (seg_end && si_q == prog_q.last_seg);
  assign take_o    = prog_valid_i && (!busy_q || (emit && item_end));

  always_comb begin
    si_d = si_q;
    bi_d = bi_q + 4'd1;
    if (seg_end) begin
      si_d = si_q + 3'd1;
      bi_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      si_q   <= '0;
      bi_q   <= '0;
    end else if (take_o) begin
      busy_q <= 1'b1;
      si_q   <= '0;
      bi_q   <= '0;
    end else if (emit) begin
      if (item_end) begin
        busy_q <= 1'b0;
      end else begin
        si_q <= si_d;
        bi_q <= bi_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) prog_q <= prog_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && emit) begin
      byte_q <= none ? 8'h00 : cur.b[bi_q];
      user_q <= {prog_q.outcome, cur.xs && bi_q == 4'd2 && !none, !none};
      last_q <= item_end;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = byte_q;
  assign m_axis_tuser_o  = user_q;
  assign m_axis_tlast_o  = last_q;

`ifndef SYNTH
  a_seg_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !none |-> si_q <= prog_q.last_seg)
    else $error("segment index past last segment");
  a_byte_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !none |-> bi_q < cur.len)
    else $error("byte index past segment length");
  a_nobyte_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !user_q[0] |-> last_q && user_q[3:2] == OutNone)
    else $error("byteless item must be last and untranslated");
  a_take_needs_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |-> prog_valid_i)
    else $error("program taken without source");
`endif

endmodule

@@ sim/tb_riscv_to_x86_code_emitter_top.sv @@
// Self-checking bench for the RISC-V to x86-64 emitter: random/directed items, byte stream check.
`timescale 1ns / 1ps
module tb_riscv_to_x86_code_emitter_top;
  import rv2x_pkg::*;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] code_byte;
    logic       exit_slot;
    logic [1:0] outcome;
    logic       last;
  } emit_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [71:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic [3:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CfgMemHelper;
  logic [63:0] cfg_data_i = '0;

  riscv_to_x86_code_emitter_top i_dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // shadow configuration
  logic [63:0] mem_addr_q, fp_addr_q;
  logic        fp_en_q;
  logic [31:0] pc_off_q;

  item_t  pending_insns[$];
  emit_t  expected_bytes[$];
  int     n_mismatch = 0, n_bytes = 0, n_insns = 0, idle_cycles = 0;
  bit     timed_out = 0, hold_off = 0;

  // ---------------- x86 byte predictor ----------------
  emit_t  code[$];

  function automatic void emit8(input logic [7:0] b);
    emit_t e;
    e = '0;
    e.byte_valid = 1'b1;
    e.code_byte = b;
    code.push_back(e);
  endfunction

  function automatic void emit32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) emit8(v[8*i +: 8]);
  endfunction

  function automatic void mov_reg(input logic [2:0] r, input logic [31:0] imm);
    emit8(8'hB8 + r);
    emit32(imm);
  endfunction

  function automatic void hart_access(input logic [7:0] opc, input logic [2:0] r,
                                      input logic [31:0] disp);
    emit8(opc);
    emit8({2'b10, r, 3'b011});
    emit32(disp);
  endfunction

  function automatic void load_gpr(input logic [2:0] r, input logic [4:0] g);
    if (g == 0) mov_reg(r, 32'h0);
    else hart_access(8'h8B, r, {25'd0, g, 2'b00});
  endfunction

  function automatic void store_gpr(input logic [4:0] g, input logic [2:0] r);
    if (g != 0) hart_access(8'h89, r, {25'd0, g, 2'b00});
  endfunction

  function automatic void alu_op(input logic [7:0] op);
    emit8(op);
    emit8(8'hC8);
  endfunction

  function automatic void set_flag(input logic [7:0] cc);
    emit8(8'h0F); emit8(cc); emit8(8'hC0);
    emit8(8'h0F); emit8(8'hB6); emit8(8'hC0);
  endfunction

  function automatic void call_helper(input logic [63:0] addr, input logic [31:0] insn,
                                      input logic [31:0] pc);
    int at;
    emit8(8'h48); emit8(8'h89); emit8(8'hDF);
    mov_reg(RegEsi, insn);
    mov_reg(RegEdx, pc);
    emit8(8'h48); emit8(8'hB8);
    emit32(addr[31:0]); emit32(addr[63:32]);
    emit8(8'hFF); emit8(8'hD0); emit8(8'h85); emit8(8'hC0);
    emit8(8'h0F); emit8(8'h85);
    at = code.size();
    emit32(32'h0);
    code[at].exit_slot = 1'b1;
  endfunction

  function automatic logic [1:0] translate_insn(input item_t it);
    logic [6:0]  op;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] nxt, imm_i, imm_br, imm_jl;
    logic [7:0]  cc;
    op = it.instruction[6:0];
    rd = it.instruction[11:7];
    rs1 = it.instruction[19:15];
    rs2 = it.instruction[24:20];
    f3 = it.instruction[14:12];
    f7 = it.instruction[31:25];
    nxt = it.insn_pc + {29'd0, it.insn_length};
    imm_i = {{20{it.instruction[31]}}, it.instruction[31:20]};
    imm_br = {{20{it.instruction[31]}}, it.instruction[7], it.instruction[30:25],
              it.instruction[11:8], 1'b0};
    imm_jl = {{12{it.instruction[31]}}, it.instruction[19:12], it.instruction[20],
              it.instruction[30:21], 1'b0};
    case (op)
      OpLui: begin
        mov_reg(RegEax, {it.instruction[31:12], 12'h0});
        store_gpr(rd, RegEax);
        return OutOk;
      end
      OpAuipc: begin
        mov_reg(RegEax, it.insn_pc + {it.instruction[31:12], 12'h0});
        store_gpr(rd, RegEax);
        return OutOk;
      end
      OpImm: begin
        if ((f3 == 1 && f7 != 0) || (f3 == 5 && f7 != 0 && f7 != 7'h20)) return OutNone;
        load_gpr(RegEax, rs1);
        case (f3)
          3'd0: begin mov_reg(RegEcx, imm_i); alu_op(8'h01); end
          3'd4: begin mov_reg(RegEcx, imm_i); alu_op(8'h31); end
          3'd6: begin mov_reg(RegEcx, imm_i); alu_op(8'h09); end
          3'd7: begin mov_reg(RegEcx, imm_i); alu_op(8'h21); end
          3'd2: begin mov_reg(RegEcx, imm_i); alu_op(8'h39); set_flag(8'h9C); end
          3'd3: begin mov_reg(RegEcx, imm_i); alu_op(8'h39); set_flag(8'h92); end
          3'd1: begin emit8(8'hC1); emit8(8'hE0); emit8({3'd0, rs2}); end
          default: begin
            emit8(8'hC1); emit8(f7 == 7'h20 ? 8'hF8 : 8'hE8); emit8({3'd0, rs2});
          end
        endcase
        store_gpr(rd, RegEax);
        return OutOk;
      end
      OpReg: begin
        if (f7 != 0 && f7 != 7'h20) return OutNone;
        if (f7 != 0 && f3 != 0 && f3 != 5) return OutNone;
        load_gpr(RegEax, rs1);
        load_gpr(RegEcx, rs2);
        case (f3)
          3'd0: alu_op(f7 == 7'h20 ? 8'h29 : 8'h01);
          3'd4: alu_op(8'h31);
          3'd6: alu_op(8'h09);
          3'd7: alu_op(8'h21);
          3'd2: begin alu_op(8'h39); set_flag(8'h9C); end
          3'd3: begin alu_op(8'h39); set_flag(8'h92); end
          3'd1: begin emit8(8'hD3); emit8(8'hE0); end
          default: begin emit8(8'hD3); emit8(f7 == 7'h20 ? 8'hF8 : 8'hE8); end
        endcase
        store_gpr(rd, RegEax);
        return OutOk;
      end
      OpLoad, OpStore: begin
        if (op == OpLoad && f3 == 3) return OutNone;
        if (op == OpStore && f3 > 2) return OutNone;
        call_helper(mem_addr_q, it.instruction, it.insn_pc);
        return OutOk;
      end
      OpFload, OpFstore, OpFp, OpFmadd, OpFmsub, OpFnmsub, OpFnmadd: begin
        if (!fp_en_q) return OutNone;
        call_helper(fp_addr_q, it.instruction, it.insn_pc);
        return OutOk;
      end
      OpBranch: begin
        if (f3 == 2 || f3 == 3) return OutNone;
        case (f3)
          3'd0: cc = 8'h84;
          3'd1: cc = 8'h85;
          3'd4: cc = 8'h8C;
          3'd5: cc = 8'h8D;
          3'd6: cc = 8'h82;
          default: cc = 8'h83;
        endcase
        load_gpr(RegEax, rs1);
        load_gpr(RegEcx, rs2);
        alu_op(8'h39);
        emit8(8'h0F); emit8(cc); emit32(32'd10);
        mov_reg(RegEax, nxt);
        emit8(8'hE9); emit32(32'd5);
        mov_reg(RegEax, it.insn_pc + imm_br);
        hart_access(8'h89, RegEax, pc_off_q);
        return OutEnd;
      end
      OpJal: begin
        mov_reg(RegEax, nxt);
        store_gpr(rd, RegEax);
        mov_reg(RegEax, it.insn_pc + imm_jl);
        hart_access(8'h89, RegEax, pc_off_q);
        return OutEnd;
      end
      OpJalr: begin
        if (f3 != 0) return OutNone;
        load_gpr(RegEax, rs1);
        mov_reg(RegEcx, imm_i);
        alu_op(8'h01);
        emit8(8'h83); emit8(8'hE0); emit8(8'hFE);
        mov_reg(RegEcx, nxt);
        store_gpr(rd, RegEcx);
        hart_access(8'h89, RegEax, pc_off_q);
        return OutEnd;
      end
      default: return OutNone;
    endcase
  endfunction

  function automatic void predict_bytes(input item_t it);
    logic [1:0] oc;
    emit_t      e;
    code.delete();
    oc = translate_insn(it);
    if (oc == OutNone || code.size() == 0) begin
      e = '0;
      e.last = 1'b1;
      expected_bytes.push_back(e);
    end else begin
      foreach (code[k]) begin
        e = code[k];
        e.outcome = oc;
        e.last = (k == code.size() - 1);
        expected_bytes.push_back(e);
      end
    end
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic logic [31:0] rand_insn();
    logic [31:0] w;
    logic [6:0]  ops[16];
    int          pick;
    ops = '{OpLui, OpAuipc, OpImm, OpReg, OpLoad, OpStore, OpFload, OpFstore, OpFp,
            OpFmadd, OpFmsub, OpFnmsub, OpFnmadd, OpBranch, OpJal, OpJalr};
    w = $urandom();
    pick = $urandom_range(0, 19);
    if (pick < 16) w[6:0] = ops[pick];
    // mostly legal funct7 for shifts and register ops
    if ((w[6:0] == OpReg || w[6:0] == OpImm) && $urandom_range(0, 3) != 0)
      w[31:25] = $urandom_range(0, 1) ? 7'h20 : 7'h00;
    if (w[6:0] == OpJalr && $urandom_range(0, 3) != 0) w[14:12] = 3'd0;
    return w;
  endfunction

  task automatic add_insn(input logic [31:0] w, input logic [31:0] pc, input logic [2:0] ln);
    item_t it;
    it.instruction = w;
    it.insn_pc = pc;
    it.insn_length = ln;
    pending_insns.push_back(it);
  endtask

  task automatic add_random(input int n);
    for (int i = 0; i < n; i++)
      add_insn(rand_insn(), $urandom(),
               ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                           : ($urandom_range(0, 1) ? 3'd4 : 3'd2));
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgMemHelper: mem_addr_q = val;
      CfgFpHelper:  fp_addr_q = val;
      CfgFpEnable:  fp_en_q = val[0];
      default:      pc_off_q = val[31:0];
    endcase
  endtask

  task automatic drain();
    while (pending_insns.size() != 0 || expected_bytes.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  // ---------------- driver ----------------
  int src_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_bytes(pending_insns.pop_front());
        n_insns++;
      end
      if (s_axis_tvalid_i && !(s_axis_tready_o)) begin
        // keep offering
      end else if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_insns.size() != 0) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= {5'd0, pending_insns[0]};
        src_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                : (($urandom_range(0, 2) == 0) ? 1 : 0);
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  int sink_gap = 0;
  always @(posedge clk_i) begin
    emit_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = {m_axis_tuser_o[0], m_axis_tdata_o, m_axis_tuser_o[1], m_axis_tuser_o[3:2],
               m_axis_tlast_o};
        n_bytes++;
        if (expected_bytes.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected byte %p", got);
        end else begin
          want = expected_bytes.pop_front();
          if (got !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("byte mismatch: expected %p got %p", want, got);
          end
        end
      end
      if (hold_off) begin
        m_axis_tready_i <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        sink_gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 60)
                                                 : (($urandom_range(0, 3) == 0) ? 1 : 0);
      end
    end
  end

  // long receiver hold-off
  initial begin
    wait (n_insns >= 40);
    hold_off = 1;
    repeat (300) @(posedge clk_i);
    hold_off = 0;
  end

  // watchdog: no traffic in either direction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000 && !timed_out) begin
      timed_out = 1;
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    mem_addr_q = '0;
    fp_addr_q = '0;
    fp_en_q = 1'b0;
    pc_off_q = 32'd128;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset configuration
    add_insn(32'h0000_0000, 32'h0, 3'd4);            // unknown opcode
    add_insn(32'hFFFF_F0B7, 32'hFFFF_FFFF, 3'd4);    // lui, all ones imm
    add_insn(32'h0000_0037, 32'h0, 3'd2);            // lui to x0
    add_insn(32'hFFFF_F097, 32'hFFFF_FFFC, 3'd4);    // auipc wrap
    add_insn(32'hFFF0_A093, 32'h100, 3'd4);          // slti, negative imm
    add_insn(32'h4000_5093, 32'h100, 3'd4);          // srai
    add_insn(32'h0200_1093, 32'h100, 3'd4);          // slli bad funct7
    add_insn(32'h4000_00B3, 32'h100, 3'd4);          // sub
    add_insn(32'h4000_10B3, 32'h100, 3'd4);          // illegal op funct7
    add_insn(32'h0000_3083, 32'h100, 3'd4);          // load f3=3
    add_insn(32'h0000_7083, 32'h100, 3'd4);          // load f3=7 goes to helper
    add_insn(32'h0000_3023, 32'h100, 3'd4);          // store f3=3
    add_insn(32'h0000_0053, 32'h100, 3'd4);          // fp while disabled
    add_insn(32'hFE00_0FE3, 32'h0, 3'd4);            // beq back, x0 operands
    add_insn(32'h7FF0_AFE3, 32'hFFFF_FFF0, 3'd2);    // branch far, f3=2
    add_insn(32'h0000_20E3, 32'h0, 3'd4);            // branch f3=2
    add_insn(32'h8000_006F, 32'h40, 3'd7);           // jal x0, odd length
    add_insn(32'hFFF0_80E7, 32'h40, 3'd0);           // jalr neg imm
    add_insn(32'h0000_10E7, 32'h40, 3'd4);           // jalr f3!=0
    drain();

    write_cfg(CfgMemHelper, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cfg(CfgFpHelper, 64'h0123_4567_89AB_CDEF);
    write_cfg(CfgFpEnable, 64'h1);
    write_cfg(CfgPcOffset, 64'hFFFF_FFFF);
    add_insn(32'h0000_0053, 32'h200, 3'd4);
    add_insn(32'hFFFF_FFA7, 32'hFFFF_FFFF, 3'd4);
    add_insn(32'hFFFF_FF83, 32'h0, 3'd4);
    add_insn(32'h0000_0063, 32'h0, 3'd4);
    add_random(33);
    drain();

    write_cfg(CfgMemHelper, $urandom());
    write_cfg(CfgFpHelper, {$urandom(), $urandom()});
    write_cfg(CfgFpEnable, 64'h0);
    write_cfg(CfgPcOffset, 64'h0);
    add_random(33);
    drain();

    write_cfg(CfgMemHelper, 64'h0);
    write_cfg(CfgFpHelper, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cfg(CfgFpEnable, 64'h1);
    write_cfg(CfgPcOffset, {32'h0, $urandom()});
    add_random(33);
    drain();

    $display("Sent %0d instructions over four configurations, checked %0d output items.",
             n_insns, n_bytes);
    if (n_mismatch == 0 && expected_bytes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
